@@ sv/rmsn_pkg.sv @@
// Package for the RMS normalization block: widths, constants and payload types.
// No dependencies; every other file of the block imports it.

package rmsn_pkg;

    // Field and state widths.
    localparam int DATA_W    = 16;
    localparam int EPS_W     = 16;
    localparam int SUM_W     = 44;
    localparam int COUNT_W   = 13;
    localparam int INV_W     = 32;
    localparam int MAX_LEN   = 4096;
    localparam int COUNT_CAP = (MAX_LEN > 8191) ? 8191 : MAX_LEN;

    // Reset value of the epsilon register, in units of 2^-24.
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd168;

    // Mean square is the quotient plus epsilon; one bit of headroom.
    localparam int MEAN_W = SUM_W + 1;
    // Divisor register holds either the count or the mean.
    localparam int DVS_W  = MEAN_W + 1;
    // Partial remainder of the shared compare/subtract unit.
    localparam int REM_W  = DVS_W + 1;
    // Quotient of 2^56 / mean needs 57 bits; the root shares the register.
    localparam int QUO_W  = 57;
    // Dividend / radicand shift register, an even width for the root.
    localparam int DVD_W  = QUO_W + 1;

    // Iteration counts of the three sequences.
    localparam int DIV1_STEPS = SUM_W;
    localparam int DIV2_STEPS = QUO_W;
    localparam int ROOT_STEPS = DVD_W / 2;
    localparam int STEP_W     = 6;

    // Shared multiplier operand and product widths.
    localparam int MA_W   = INV_W + 1;
    localparam int MB_W   = DATA_W + 1;
    localparam int PROD_W = MA_W + MB_W;

    // Action codes.
    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_SCALE = 1'b1;

    // Input request.
    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] element_value;
        logic signed [DATA_W-1:0] weight_value;
        logic                     last_element;
    } in_req_t;

    // Output result.
    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     saturated;
    } out_rsp_t;

    // Result of the shared compare/subtract unit.
    typedef struct packed {
        logic             ge;
        logic [REM_W-1:0] diff;
    } cs_res_t;

endpackage

@@ sv/rmsn_cmpsub.sv @@
// Shared compare/subtract unit used by the restoring divide and square root.
// Depends on rmsn_pkg for widths and the result struct.

module rmsn_cmpsub
    import rmsn_pkg::*;
(
    input  logic [REM_W-1:0] a,
    input  logic [REM_W-1:0] b,
    output cs_res_t          res
);

    logic [REM_W:0] wide;

    // One wide subtract; the borrow tells whether a is at least b.
    assign wide     = {1'b0, a} - {1'b0, b};
    assign res.ge   = ~wide[REM_W];
    assign res.diff = wide[REM_W-1:0];

endmodule

@@ sv/rmsn_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on rmsn_pkg for operand widths.

module rmsn_mul
    import rmsn_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [MA_W-1:0]   a,
    input  logic signed [MB_W-1:0]   b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // The product is held until the next enabled multiply.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

@@ sv/rms_norm_vector.sv @@
// Top level of the RMS normalization block: sequencer, state and output register.
// Depends on rmsn_pkg, rmsn_mul and rmsn_cmpsub.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    in_data  (in_req_t)
//   out      output     out_valid/out_ready  out_data (out_rsp_t)
//   cfg      input      cfg_we               cfg_wdata (epsilon, 16 bits)
//
// An accumulate request squares its element and a scale request passes through
// the shared multiplier. The closing accumulate request runs a 44-step divide
// by the count, a 57-step divide of 2^56 by the mean and a 29-step square root,
// all on one shared compare/subtract unit; a zero mean skips the last two.
// in_ready is high only while the sequencer is idle. The output register lets a
// result wait for out_ready while the next request is taken; a scale request
// that finishes while the register is still full holds until it drains.
// rst_n clears the sum, count, scale and sequencer asynchronously; epsilon
// returns to 168.

module rms_norm_vector
    import rmsn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_req_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_rsp_t         out_data,
    input  logic             cfg_we,
    input  logic [EPS_W-1:0] cfg_wdata
);

    localparam int R_W = PROD_W - 14;
    localparam logic signed [R_W-1:0] R_MAX = R_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
    localparam logic signed [R_W-1:0] R_MIN = -R_MAX - R_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_ACC,
        ST_DIV1,
        ST_EPS,
        ST_DIV2,
        ST_ROOT_LD,
        ST_SQRT,
        ST_FIN,
        ST_MUL1,
        ST_MUL2,
        ST_SAT
    } state_t;

    // Control and state registers.
    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    out_rsp_t             out_data_reg, out_data_next;
    logic [EPS_W-1:0]     eps_reg, eps_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [INV_W-1:0]     inv_reg, inv_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    // Datapath registers.
    logic signed [DATA_W-1:0] elem_reg, elem_next;
    logic signed [DATA_W-1:0] weight_reg, weight_next;
    logic                     last_reg, last_next;
    logic [DVD_W-1:0]         dvd_reg, dvd_next;
    logic [DVS_W-1:0]         dvs_reg, dvs_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;

    // Shared unit connections.
    logic                     mul_en;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [REM_W-1:0]         cs_a, cs_b;
    cs_res_t                  cs;

    // Derived values.
    logic [SUM_W:0]           sum_add;
    logic [SUM_W-1:0]         sum_new;
    logic [COUNT_W-1:0]       cnt_new;
    logic [COUNT_W-1:0]       cnt_div;
    logic [MEAN_W-1:0]        mean;
    logic signed [INV_W-1:0]  scaled;
    logic signed [R_W-1:0]    r_full;
    out_rsp_t                 sat_rsp;

    rmsn_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    rmsn_cmpsub u_cmpsub (
        .a   (cs_a),
        .b   (cs_b),
        .res (cs)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Saturating sum and count update from the registered square.
    assign sum_add = {1'b0, sum_reg} + {1'b0, prod[SUM_W-1:0]};
    assign sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign cnt_new = (cnt_reg < COUNT_W'(COUNT_CAP)) ? cnt_reg + COUNT_W'(1) : cnt_reg;
    assign cnt_div = (cnt_new == '0) ? COUNT_W'(1) : cnt_new;

    // Mean square from the first quotient.
    assign mean = {1'b0, quo_reg[SUM_W-1:0]} + MEAN_W'(eps_reg);

    // Floor shifts of the two products.
    assign scaled = prod[INV_W+15:16];
    assign r_full = prod[R_W+11:12];

    // Output clamp.
    always_comb
    begin
        sat_rsp.saturated    = 1'b0;
        sat_rsp.result_value = r_full[DATA_W-1:0];
        if (r_full > R_MAX)
        begin
            sat_rsp.saturated    = 1'b1;
            sat_rsp.result_value = R_MAX[DATA_W-1:0];
        end
        else if (r_full < R_MIN)
        begin
            sat_rsp.saturated    = 1'b1;
            sat_rsp.result_value = R_MIN[DATA_W-1:0];
        end
    end

    // Compare/subtract operands: a divide step or a square root step.
    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            cs_a = {rem_reg[REM_W-3:0], dvd_reg[DVD_W-1:DVD_W-2]};
            cs_b = {quo_reg[REM_W-3:0], 2'b01};
        end
        else
        begin
            cs_a = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
            cs_b = {1'b0, dvs_reg};
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        eps_next       = eps_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        inv_next       = inv_reg;
        step_next      = step_reg;
        elem_next      = elem_reg;
        weight_next    = weight_reg;
        last_next      = last_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        mul_en         = 1'b0;
        mul_a          = {{(MA_W-DATA_W){elem_reg[DATA_W-1]}}, elem_reg};
        mul_b          = {elem_reg[DATA_W-1], elem_reg};

        if (cfg_we)
        begin
            eps_next = cfg_wdata;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    elem_next   = in_data.element_value;
                    weight_next = in_data.weight_value;
                    last_next   = in_data.last_element;
                    state_next  = (in_data.action == ACT_SCALE) ? ST_MUL1 : ST_SQ;
                end
            end

            ST_SQ:
            begin
                mul_en     = 1'b1;
                state_next = ST_ACC;
            end

            ST_ACC:
            begin
                sum_next = sum_new;
                cnt_next = cnt_new;
                if (last_reg)
                begin
                    dvd_next   = {sum_new, (DVD_W-SUM_W)'(0)};
                    dvs_next   = DVS_W'(cnt_div);
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DIV1, ST_DIV2:
            begin
                rem_next  = cs.ge ? cs.diff : cs_a;
                quo_next  = {quo_reg[QUO_W-2:0], cs.ge};
                dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (state_reg == ST_DIV1 && step_reg == STEP_W'(DIV1_STEPS - 1))
                begin
                    state_next = ST_EPS;
                end
                else if (state_reg == ST_DIV2 && step_reg == STEP_W'(DIV2_STEPS - 1))
                begin
                    state_next = ST_ROOT_LD;
                end
            end

            ST_EPS:
            begin
                if (mean == '0)
                begin
                    // Zero mean: every scale qualifies, so take the largest.
                    inv_next   = '1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    dvd_next   = {1'b1, (DVD_W-1)'(0)};
                    dvs_next   = {1'b0, mean};
                    rem_next   = '0;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV2;
                end
            end

            ST_ROOT_LD:
            begin
                dvd_next   = {1'b0, quo_reg};
                rem_next   = '0;
                quo_next   = '0;
                step_next  = '0;
                state_next = ST_SQRT;
            end

            ST_SQRT:
            begin
                rem_next  = cs.ge ? cs.diff : cs_a;
                quo_next  = {quo_reg[QUO_W-2:0], cs.ge};
                dvd_next  = {dvd_reg[DVD_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                inv_next   = quo_reg[INV_W-1:0];
                state_next = ST_IDLE;
            end

            ST_MUL1:
            begin
                mul_en     = 1'b1;
                mul_a      = {1'b0, inv_reg};
                state_next = ST_MUL2;
            end

            ST_MUL2:
            begin
                mul_en     = 1'b1;
                mul_a      = {scaled[INV_W-1], scaled};
                mul_b      = {weight_reg[DATA_W-1], weight_reg};
                state_next = ST_SAT;
            end

            ST_SAT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sat_rsp;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            eps_reg       <= EPS_RESET;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            inv_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            eps_reg       <= eps_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            inv_reg       <= inv_next;
            step_reg      <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        elem_reg   <= elem_next;
        weight_reg <= weight_next;
        last_reg   <= last_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

`ifndef SYNTHESIS
    // A non-closing accumulate request returns the block to idle after the square and accumulate states.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.action == ACT_ACCUM && !in_data.last_element)
        |-> ##3 in_ready)
        else $error("accumulate request did not return to idle");

    // During either divide the partial remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1 || state_reg == ST_DIV2) |-> (rem_reg < {1'b0, dvs_reg}))
        else $error("divide remainder out of range");

    // Sum and count are cleared once the closing sequence starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1) |-> (sum_reg == '0 && cnt_reg == '0))
        else $error("sum or count not cleared on closing request");

    // A result appears only out of the clamp stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_SAT))
        else $error("result produced outside the clamp stage");

    // A saturated result sits at one end of the output range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.saturated)
        |-> (out_data_reg.result_value == R_MAX[DATA_W-1:0]
             || out_data_reg.result_value == R_MIN[DATA_W-1:0]))
        else $error("saturated flag with an unclamped value");
`endif

endmodule
